// ===== hw/rtl/lmc_pkg.sv =====
package lmc_pkg;

  localparam int DEFAULT_TIME_WIDTH = 32;

  // Field widths fixed by the item formats.
  localparam int TIME_MS_W   = 32;
  localparam int VERB_W      = 4;
  localparam int ARG_W       = 16;
  localparam int MODE_W      = 4;
  localparam int RC_W        = 3;
  localparam int HUE_W       = 9;
  localparam int DUR_W       = 16;
  localparam int CODE_W      = 16;
  localparam int TIMEOUT_W   = 24;
  localparam int XFADE_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 152;

  // Modes.
  localparam logic [MODE_W-1:0] MD_BOOT      = 4'd0;
  localparam logic [MODE_W-1:0] MD_IDLE      = 4'd1;
  localparam logic [MODE_W-1:0] MD_PLAYFUL   = 4'd2;
  localparam logic [MODE_W-1:0] MD_READY     = 4'd3;
  localparam logic [MODE_W-1:0] MD_COUNTDOWN = 4'd4;
  localparam logic [MODE_W-1:0] MD_CAPTURE   = 4'd5;
  localparam logic [MODE_W-1:0] MD_PRINTING  = 4'd6;
  localparam logic [MODE_W-1:0] MD_FINISHED  = 4'd7;
  localparam logic [MODE_W-1:0] MD_TEST      = 4'd8;
  localparam logic [MODE_W-1:0] MD_ERROR     = 4'd9;
  localparam logic [MODE_W-1:0] MD_LINKLOST  = 4'd10;

  // Host verbs.
  localparam logic [VERB_W-1:0] VB_PING      = 4'd0;
  localparam logic [VERB_W-1:0] VB_IDLE      = 4'd1;
  localparam logic [VERB_W-1:0] VB_RELEASE   = 4'd2;
  localparam logic [VERB_W-1:0] VB_READY     = 4'd3;
  localparam logic [VERB_W-1:0] VB_PHASE     = 4'd4;
  localparam logic [VERB_W-1:0] VB_COUNTDOWN = 4'd5;
  localparam logic [VERB_W-1:0] VB_CAPTURE   = 4'd6;
  localparam logic [VERB_W-1:0] VB_PRINTING  = 4'd7;
  localparam logic [VERB_W-1:0] VB_FINISHED  = 4'd8;
  localparam logic [VERB_W-1:0] VB_TEST      = 4'd9;
  localparam logic [VERB_W-1:0] VB_ERROR     = 4'd10;

  // Reply codes.
  localparam logic [RC_W-1:0] RC_PONG    = 3'd0;
  localparam logic [RC_W-1:0] RC_OK      = 3'd1;
  localparam logic [RC_W-1:0] RC_RANGE   = 3'd2;
  localparam logic [RC_W-1:0] RC_UNKNOWN = 3'd3;
  localparam logic [RC_W-1:0] RC_NONE    = 3'd4;

  // Item kinds.
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PRINTING_TIMEOUT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPTURE_TIMEOUT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TEST_TIMEOUT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_TIMEOUT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSSFADE        = 3'd4;

  localparam logic [TIMEOUT_W-1:0] PRINTING_TIMEOUT_RST = 24'd120000;
  localparam logic [TIMEOUT_W-1:0] CAPTURE_TIMEOUT_RST  = 24'd10000;
  localparam logic [TIMEOUT_W-1:0] TEST_TIMEOUT_RST     = 24'd300000;
  localparam logic [TIMEOUT_W-1:0] LINK_TIMEOUT_RST     = 24'd10000;
  localparam logic [XFADE_W-1:0]   CROSSFADE_RST        = 16'd300;

  localparam logic [ARG_W-1:0]  HUE_MAX      = 16'd359;
  localparam logic [ARG_W-1:0]  DUR_MAX      = 16'd60000;
  localparam logic [ARG_W-1:0]  TEST_LAST_CH = 16'd3;
  localparam logic [CODE_W-1:0] TEST_ALL     = 16'd4;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] printing_timeout;
    logic [TIMEOUT_W-1:0] capture_timeout;
    logic [TIMEOUT_W-1:0] test_timeout;
    logic [TIMEOUT_W-1:0] link_timeout;
    logic [XFADE_W-1:0]   crossfade;
  } cfg_t;

  typedef struct packed {
    logic                 operation;
    logic [TIME_MS_W-1:0] time_ms;
    logic [VERB_W-1:0]    verb;
    logic [ARG_W-1:0]     arg;
  } item_t;

  typedef struct packed {
    logic [RC_W-1:0]      reply_code;
    logic [MODE_W-1:0]    mode;
    logic [MODE_W-1:0]    prev_mode;
    logic [TIME_MS_W-1:0] mode_age;
    logic [TIME_MS_W-1:0] prev_mode_age;
    logic [TIME_MS_W-1:0] link_age;
    logic                 crossfade_active;
    logic                 apply_dimming;
    logic [HUE_W-1:0]     hue;
    logic [DUR_W-1:0]     dur_val;
    logic [CODE_W-1:0]    code;
  } result_t;

endpackage

// ===== hw/rtl/led_mode_controller_with_watchdog_unit.sv =====
// LED ring mode controller with a host link watchdog.
//
// Input items arrive on the s_ channel. s_tuser carries the item kind: a host
// command or a frame tick. s_tdata carries the timestamp, the verb and the
// argument. Every accepted item produces exactly one result item on the m_
// channel with the reply code, the current and previous modes, the elapsed
// times, the cross-fade and dimming flags and the current hue, duration and
// code.
// An item is registered at the input, its state update is one combinational
// pass, and the result is registered at the output: m_tvalid rises as the item
// leaves the input register, and one item is accepted every cycle while m_tready stays high.
// The mode state is updated in the cycle the item moves into the output
// register, so the next item always sees the effect of the previous one.
// If the receiver stalls, the result holds in the output register and one more
// item waits in the input register; s_tready drops only when both are full.
// Configuration registers are written through cfg_wen, cfg_index and cfg_data;
// the user must write them only while the block is idle, as the block does not
// enforce it. Writes to indexes past the last register are ignored. Reset
// (synchronous, active high) empties both registers, restores the default timeouts
// and puts the controller in boot mode with all parameters and timestamps cleared.
module led_mode_controller_with_watchdog_unit #(
  parameter int TIME_WIDTH = lmc_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // time_ms[31:0], verb[35:32], arg[51:36], zero pad[55:52]
  input  logic [lmc_pkg::S_TDATA_W-1:0]        s_tdata,
  // operation[0]: 0 host command, 1 frame tick
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // reply_code[2:0], mode[6:3], prev_mode[10:7], mode_age[42:11],
  // prev_mode_age[74:43], link_age[106:75], crossfade_active[107],
  // apply_dimming[108], hue[117:109], dur_val[133:118], code[149:134],
  // zero pad[151:150]
  output logic [lmc_pkg::M_TDATA_W-1:0]        m_tdata,
  input  logic                                 cfg_wen,
  input  logic [lmc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  lmc_pkg::cfg_t    cfg;
  lmc_pkg::item_t   in_item;
  lmc_pkg::result_t core_res;
  lmc_pkg::result_t out_res;
  logic             in_valid;
  logic             advance;
  logic             s_fire;

  // The input stage moves on when the output register is empty or being drained.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item.operation <= s_tuser;
      in_item.time_ms   <= s_tdata[31:0];
      in_item.verb      <= s_tdata[35:32];
      in_item.arg       <= s_tdata[51:36];
    end
  end

  lmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {2'b00,
                    out_res.code,
                    out_res.dur_val,
                    out_res.hue,
                    out_res.apply_dimming,
                    out_res.crossfade_active,
                    out_res.link_age,
                    out_res.prev_mode_age,
                    out_res.mode_age,
                    out_res.prev_mode,
                    out_res.mode,
                    out_res.reply_code};

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output register was empty");

  a_capture_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.mode == lmc_pkg::MD_CAPTURE |->
      !out_res.crossfade_active && !out_res.apply_dimming)
    else $error("capture mode result has cross-fade or dimming set");

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("item left the input stage without a result");

endmodule

// ===== hw/rtl/lmc_cfg_regs.sv =====
module lmc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [lmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output lmc_pkg::cfg_t                       cfg
);

  // Writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.printing_timeout <= lmc_pkg::PRINTING_TIMEOUT_RST;
      cfg.capture_timeout  <= lmc_pkg::CAPTURE_TIMEOUT_RST;
      cfg.test_timeout     <= lmc_pkg::TEST_TIMEOUT_RST;
      cfg.link_timeout     <= lmc_pkg::LINK_TIMEOUT_RST;
      cfg.crossfade        <= lmc_pkg::CROSSFADE_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lmc_pkg::REG_PRINTING_TIMEOUT: cfg.printing_timeout <= cfg_data;
        lmc_pkg::REG_CAPTURE_TIMEOUT:  cfg.capture_timeout  <= cfg_data;
        lmc_pkg::REG_TEST_TIMEOUT:     cfg.test_timeout     <= cfg_data;
        lmc_pkg::REG_LINK_TIMEOUT:     cfg.link_timeout     <= cfg_data;
        lmc_pkg::REG_CROSSFADE:        cfg.crossfade        <= cfg_data[lmc_pkg::XFADE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lmc_core.sv =====
module lmc_core #(
  parameter int TIME_WIDTH = lmc_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  lmc_pkg::item_t   item,
  input  lmc_pkg::cfg_t    cfg,
  output lmc_pkg::result_t res
);

  logic [lmc_pkg::MODE_W-1:0] cur_mode, cur_mode_next;
  logic [lmc_pkg::MODE_W-1:0] last_mode, last_mode_next;
  logic [TIME_WIDTH-1:0]      entry_time, entry_time_next;
  logic [TIME_WIDTH-1:0]      last_entry_time, last_entry_time_next;
  logic [TIME_WIDTH-1:0]      last_rx_time, last_rx_time_next;
  logic [lmc_pkg::HUE_W-1:0]  hue, hue_next;
  logic [lmc_pkg::DUR_W-1:0]  duration, duration_next;
  logic [lmc_pkg::CODE_W-1:0] code, code_next;

  logic [TIME_WIDTH-1:0]      t;
  logic [TIME_WIDTH-1:0]      el0, pel0, since0;
  logic [TIME_WIDTH-1:0]      el_out, pel_out, since_out;
  logic [lmc_pkg::RC_W-1:0]   rc;
  logic                       enter;
  logic                       keep;
  logic [lmc_pkg::MODE_W-1:0] new_mode;
  logic                       is_cmd;

  assign t      = TIME_WIDTH'(item.time_ms);
  assign is_cmd = (item.operation == lmc_pkg::OP_COMMAND);
  assign el0    = t - entry_time;
  assign pel0   = t - last_entry_time;
  assign since0 = t - last_rx_time;

  always_comb begin
    cur_mode_next        = cur_mode;
    last_mode_next       = last_mode;
    entry_time_next      = entry_time;
    last_entry_time_next = last_entry_time;
    last_rx_time_next    = last_rx_time;
    hue_next             = hue;
    duration_next        = duration;
    code_next            = code;
    rc                   = lmc_pkg::RC_NONE;
    enter                = 1'b0;
    keep                 = 1'b0;
    new_mode             = cur_mode;
    el_out               = el0;
    pel_out              = pel0;
    since_out            = since0;

    if (is_cmd) begin
      last_rx_time_next = t;
      since_out         = '0;
      rc                = lmc_pkg::RC_OK;
      unique case (item.verb)
        lmc_pkg::VB_PING: begin
          rc = lmc_pkg::RC_PONG;
          if (cur_mode == lmc_pkg::MD_BOOT || cur_mode == lmc_pkg::MD_LINKLOST) begin
            enter    = 1'b1;
            new_mode = lmc_pkg::MD_IDLE;
          end
        end
        lmc_pkg::VB_IDLE, lmc_pkg::VB_RELEASE: begin
          enter    = 1'b1;
          new_mode = lmc_pkg::MD_IDLE;
        end
        lmc_pkg::VB_READY: begin
          enter    = 1'b1;
          new_mode = lmc_pkg::MD_READY;
        end
        lmc_pkg::VB_PHASE: begin
          if (item.arg > lmc_pkg::HUE_MAX) begin
            rc = lmc_pkg::RC_RANGE;
          end else begin
            hue_next = item.arg[lmc_pkg::HUE_W-1:0];
            enter    = 1'b1;
            keep     = 1'b1;
            new_mode = lmc_pkg::MD_PLAYFUL;
          end
        end
        lmc_pkg::VB_COUNTDOWN, lmc_pkg::VB_FINISHED: begin
          if (item.arg == '0 || item.arg > lmc_pkg::DUR_MAX) begin
            rc = lmc_pkg::RC_RANGE;
          end else begin
            duration_next = item.arg;
            enter         = 1'b1;
            keep          = 1'b1;
            new_mode      = (item.verb == lmc_pkg::VB_COUNTDOWN) ?
                            lmc_pkg::MD_COUNTDOWN : lmc_pkg::MD_FINISHED;
          end
        end
        lmc_pkg::VB_CAPTURE: begin
          enter    = 1'b1;
          new_mode = lmc_pkg::MD_CAPTURE;
        end
        lmc_pkg::VB_PRINTING: begin
          enter    = 1'b1;
          new_mode = lmc_pkg::MD_PRINTING;
        end
        lmc_pkg::VB_TEST: begin
          code_next = (item.arg > lmc_pkg::TEST_LAST_CH) ? lmc_pkg::TEST_ALL : item.arg;
          enter     = 1'b1;
          keep      = 1'b1;
          new_mode  = lmc_pkg::MD_TEST;
        end
        lmc_pkg::VB_ERROR: begin
          code_next = item.arg;
          enter     = 1'b1;
          keep      = 1'b1;
          new_mode  = lmc_pkg::MD_ERROR;
        end
        default: rc = lmc_pkg::RC_UNKNOWN;
      endcase
    end else begin
      // Per-mode timeouts fire only when the elapsed time strictly exceeds the limit.
      unique case (cur_mode)
        lmc_pkg::MD_PRINTING: begin
          enter    = (el0 > cfg.printing_timeout);
          new_mode = lmc_pkg::MD_ERROR;
        end
        lmc_pkg::MD_CAPTURE: begin
          enter    = (el0 > cfg.capture_timeout);
          new_mode = lmc_pkg::MD_IDLE;
        end
        lmc_pkg::MD_TEST: begin
          enter    = (el0 > cfg.test_timeout);
          new_mode = lmc_pkg::MD_IDLE;
        end
        lmc_pkg::MD_FINISHED: begin
          enter    = (duration != '0) && (el0 > duration);
          new_mode = lmc_pkg::MD_IDLE;
        end
        default: ;
      endcase
    end

    if (enter) begin
      last_mode_next       = cur_mode;
      last_entry_time_next = entry_time;
      cur_mode_next        = new_mode;
      entry_time_next      = t;
      pel_out              = el0;
      el_out               = '0;
      if (!keep) begin
        hue_next      = '0;
        duration_next = '0;
        code_next     = '0;
      end
    end

    // The watchdog looks at the mode left by the timeout, so both can fire in one tick.
    if (!is_cmd && cur_mode_next != lmc_pkg::MD_BOOT &&
        cur_mode_next != lmc_pkg::MD_LINKLOST && since0 > cfg.link_timeout) begin
      last_mode_next       = cur_mode_next;
      last_entry_time_next = entry_time_next;
      cur_mode_next        = lmc_pkg::MD_LINKLOST;
      entry_time_next      = t;
      pel_out              = el_out;
      el_out               = '0;
      hue_next             = '0;
      duration_next        = '0;
      code_next            = '0;
    end
  end

  always_comb begin
    res.reply_code       = rc;
    res.mode             = cur_mode_next;
    res.prev_mode        = last_mode_next;
    res.mode_age         = lmc_pkg::TIME_MS_W'(el_out);
    res.prev_mode_age    = lmc_pkg::TIME_MS_W'(pel_out);
    res.link_age         = lmc_pkg::TIME_MS_W'(since_out);
    res.crossfade_active = (el_out < cfg.crossfade) &&
                           (cur_mode_next != lmc_pkg::MD_CAPTURE) &&
                           (last_mode_next != cur_mode_next);
    res.apply_dimming    = (cur_mode_next != lmc_pkg::MD_CAPTURE) &&
                           (cur_mode_next != lmc_pkg::MD_TEST);
    res.hue              = hue_next;
    res.dur_val          = duration_next;
    res.code             = code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode        <= lmc_pkg::MD_BOOT;
      last_mode       <= lmc_pkg::MD_BOOT;
      entry_time      <= '0;
      last_entry_time <= '0;
      last_rx_time    <= '0;
      hue             <= '0;
      duration        <= '0;
      code            <= '0;
    end else if (fire) begin
      cur_mode        <= cur_mode_next;
      last_mode       <= last_mode_next;
      entry_time      <= entry_time_next;
      last_entry_time <= last_entry_time_next;
      last_rx_time    <= last_rx_time_next;
      hue             <= hue_next;
      duration        <= duration_next;
      code            <= code_next;
    end
  end

  a_cmd_refreshes_link: assert property (@(posedge clk) disable iff (rst)
    fire && is_cmd |=> last_rx_time == $past(t))
    else $error("command did not refresh the link time");

  a_mode_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_mode <= lmc_pkg::MD_LINKLOST && last_mode <= lmc_pkg::MD_LINKLOST)
    else $error("mode register holds an undefined code");

  a_tick_keeps_params: assert property (@(posedge clk) disable iff (rst)
    fire && !is_cmd |=> (cur_mode != $past(cur_mode)) ||
      (hue == $past(hue) && duration == $past(duration) && code == $past(code)))
    else $error("frame tick changed parameters without a mode entry");

  a_linklost_clears: assert property (@(posedge clk) disable iff (rst)
    fire && !is_cmd && cur_mode_next == lmc_pkg::MD_LINKLOST &&
      cur_mode != lmc_pkg::MD_LINKLOST |=> hue == '0 && duration == '0 && code == '0)
    else $error("link lost entry kept parameters");

endmodule
